/* rtl/core/ece_pkg.sv */
// Shared constants, codes and item types for the easing curve evaluator.
package ece_pkg;

   localparam int TIME_BITS  = 16;
   localparam int VALUE_BITS = 16;

   // Q16 fixed point
   localparam int Q_FRAC = 16;
   localparam int Q_ONE  = 1 << Q_FRAC;
   localparam int Q_HALF = 1 << (Q_FRAC - 1);

   localparam int P_W       = Q_FRAC + 1;   // progress 0 .. Q_ONE
   localparam int DIV_STEPS = P_W;          // one quotient bit per divider stage
   localparam int OVS_W     = 18;           // overshoot register width
   localparam int OUT_W     = VALUE_BITS + 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_OVERSHOOT = 1'b0;   // word index bit paddr[2]
   localparam logic [OVS_W-1:0] OVERSHOOT_RESET = OVS_W'(85197);

   // curve selection
   localparam logic [3:0] MODE_LINEAR        = 4'd0;
   localparam logic [3:0] MODE_QUAD_IN       = 4'd1;
   localparam logic [3:0] MODE_QUAD_OUT      = 4'd2;
   localparam logic [3:0] MODE_QUAD_INOUT    = 4'd3;
   localparam logic [3:0] MODE_CUBIC_IN      = 4'd4;
   localparam logic [3:0] MODE_CUBIC_OUT     = 4'd5;
   localparam logic [3:0] MODE_CUBIC_INOUT   = 4'd6;
   localparam logic [3:0] MODE_QUARTIC_IN    = 4'd7;
   localparam logic [3:0] MODE_QUARTIC_OUT   = 4'd8;
   localparam logic [3:0] MODE_QUARTIC_INOUT = 4'd9;
   localparam logic [3:0] MODE_BACK_OUT      = 4'd10;

   localparam logic [1:0] KIND_IN    = 2'd0;
   localparam logic [1:0] KIND_OUT   = 2'd1;
   localparam logic [1:0] KIND_INOUT = 2'd2;
   localparam logic [1:0] KIND_BACK  = 2'd3;

   localparam logic [1:0] POW_1 = 2'd0;
   localparam logic [1:0] POW_2 = 2'd1;
   localparam logic [1:0] POW_3 = 2'd2;
   localparam logic [1:0] POW_4 = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_CLAMP = 2'd1;
   localparam logic [1:0] STATUS_ZERO  = 2'd2;

   typedef struct packed {
      logic [P_W-1:0]               progress;
      logic [1:0]                   kind;
      logic [1:0]                   power;
      logic signed [VALUE_BITS-1:0] start_value;
      logic signed [VALUE_BITS-1:0] change;
      logic [1:0]                   status;
   } ece_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ece_qstat_type;

endpackage

/* rtl/core/ece_front.sv */
// Front end: request capture, clamp, curve classification and the progress divider.
module ece_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [3:0]                            mode,
   input  logic [ece_pkg::TIME_BITS-1:0]         elapsed,
   input  logic [ece_pkg::TIME_BITS-1:0]         duration,
   input  logic signed [ece_pkg::VALUE_BITS-1:0] start_value,
   input  logic signed [ece_pkg::VALUE_BITS-1:0] change,
   input  ece_pkg::ece_qstat_type                qstat,
   output logic                                  push,
   output ece_pkg::ece_item_type                 push_item
);
   import ece_pkg::*;

   logic advance;

   logic                 cap_vld_ff, cap_vld_in;
   logic [TIME_BITS-1:0] cap_t_ff, cap_t_in;
   logic [TIME_BITS-1:0] cap_d_ff;
   ece_item_type         cap_item_ff, cap_item_in;

   logic                 div_vld_ff  [DIV_STEPS];
   logic [TIME_BITS-1:0] div_rem_ff  [DIV_STEPS];
   logic [P_W-1:0]       div_quo_ff  [DIV_STEPS];
   logic [TIME_BITS-1:0] div_den_ff  [DIV_STEPS];
   ece_item_type         div_item_ff [DIV_STEPS];

   logic                 div_vld_in  [DIV_STEPS];
   logic [TIME_BITS-1:0] div_rem_in  [DIV_STEPS];
   logic [P_W-1:0]       div_quo_in  [DIV_STEPS];
   logic [TIME_BITS-1:0] div_den_in  [DIV_STEPS];
   ece_item_type         div_item_in [DIV_STEPS];

   assign advance = !qstat.full;
   assign busy    = !advance;

   // clamp and classify
   always_comb begin
      cap_vld_in  = start;
      cap_t_in    = (elapsed > duration) ? duration : elapsed;
      cap_item_in = '0;
      cap_item_in.start_value = start_value;
      cap_item_in.change      = change;
      priority if (duration == '0) begin
         cap_item_in.status = STATUS_ZERO;
      end else if (elapsed > duration) begin
         cap_item_in.status = STATUS_CLAMP;
      end else begin
         cap_item_in.status = STATUS_OK;
      end
      unique case (mode)
         MODE_QUAD_IN:       begin cap_item_in.kind = KIND_IN;    cap_item_in.power = POW_2; end
         MODE_QUAD_OUT:      begin cap_item_in.kind = KIND_OUT;   cap_item_in.power = POW_2; end
         MODE_QUAD_INOUT:    begin cap_item_in.kind = KIND_INOUT; cap_item_in.power = POW_2; end
         MODE_CUBIC_IN:      begin cap_item_in.kind = KIND_IN;    cap_item_in.power = POW_3; end
         MODE_CUBIC_OUT:     begin cap_item_in.kind = KIND_OUT;   cap_item_in.power = POW_3; end
         MODE_CUBIC_INOUT:   begin cap_item_in.kind = KIND_INOUT; cap_item_in.power = POW_3; end
         MODE_QUARTIC_IN:    begin cap_item_in.kind = KIND_IN;    cap_item_in.power = POW_4; end
         MODE_QUARTIC_OUT:   begin cap_item_in.kind = KIND_OUT;   cap_item_in.power = POW_4; end
         MODE_QUARTIC_INOUT: begin cap_item_in.kind = KIND_INOUT; cap_item_in.power = POW_4; end
         MODE_BACK_OUT:      begin cap_item_in.kind = KIND_BACK;  cap_item_in.power = POW_1; end
         // linear and undefined modes: p to the first power
         default:            begin cap_item_in.kind = KIND_IN;    cap_item_in.power = POW_1; end
      endcase
   end

   // restoring divider, one quotient bit per stage, MSB (weight Q_ONE) first
   always_comb begin
      logic [TIME_BITS-1:0] src_rem;
      logic [P_W-1:0]       src_quo;
      logic [TIME_BITS:0]   trial;
      logic                 qbit;
      for (int i = 0; i < DIV_STEPS; i++) begin
         if (i == 0) begin
            src_rem        = cap_t_ff;
            src_quo        = '0;
            div_vld_in[i]  = cap_vld_ff;
            div_den_in[i]  = cap_d_ff;
            div_item_in[i] = cap_item_ff;
            trial          = {1'b0, src_rem};
         end else begin
            src_rem        = div_rem_ff[i-1];
            src_quo        = div_quo_ff[i-1];
            div_vld_in[i]  = div_vld_ff[i-1];
            div_den_in[i]  = div_den_ff[i-1];
            div_item_in[i] = div_item_ff[i-1];
            trial          = {src_rem, 1'b0};
         end
         qbit          = (trial >= {1'b0, div_den_in[i]});
         div_rem_in[i] = qbit ? TIME_BITS'(trial - {1'b0, div_den_in[i]}) : TIME_BITS'(trial);
         div_quo_in[i] = {src_quo[P_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_vld_ff <= 1'b0;
         for (int i = 0; i < DIV_STEPS; i++) begin
            div_vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         cap_vld_ff <= cap_vld_in;
         for (int i = 0; i < DIV_STEPS; i++) begin
            div_vld_ff[i] <= div_vld_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cap_t_ff    <= cap_t_in;
         cap_d_ff    <= duration;
         cap_item_ff <= cap_item_in;
         for (int i = 0; i < DIV_STEPS; i++) begin
            div_rem_ff[i]  <= div_rem_in[i];
            div_quo_ff[i]  <= div_quo_in[i];
            div_den_ff[i]  <= div_den_in[i];
            div_item_ff[i] <= div_item_in[i];
         end
      end
   end

   always_comb begin
      push               = div_vld_ff[DIV_STEPS-1] && advance;
      push_item          = div_item_ff[DIV_STEPS-1];
      push_item.progress = div_quo_ff[DIV_STEPS-1];
   end

endmodule

/* rtl/core/ece_queue.sv */
// Short queue that decouples the front end from the curve back end.
module ece_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ece_pkg::ece_item_type  push_item,
   input  logic                   pop,
   output ece_pkg::ece_item_type  head_item,
   output ece_pkg::ece_qstat_type qstat
);
   import ece_pkg::*;

   ece_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = QCNT_W'(count_ff + 1'b1);
         2'b01:   count_in = QCNT_W'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/ece_back.sv */
// Back end: curve evaluation in Q16 and the final scaled, rounded, saturated value.
module ece_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  head_valid,
   input  ece_pkg::ece_item_type                 head_item,
   input  logic [ece_pkg::OVS_W-1:0]             overshoot,
   output logic                                  rsp_valid,
   output logic signed [ece_pkg::OUT_W-1:0]      rsp_value,
   output logic [1:0]                            rsp_status
);
   import ece_pkg::*;

   localparam int X_W   = Q_FRAC + 2;          // signed curve operand
   localparam int SQ_W  = 2 * X_W;
   localparam int K_W   = OVS_W + 2;           // s + 1
   localparam int KX_W  = K_W + X_W;
   localparam int A_W   = OVS_W + 4;
   localparam int UA_W  = X_W + A_W;
   localparam int F_W   = Q_FRAC + 8;
   localparam int CF_W  = VALUE_BITS + F_W;
   localparam int CR_W  = CF_W - Q_FRAC;
   localparam int SUM_W = CR_W + 1;
   localparam int STAGES = 7;

   localparam logic signed [SQ_W-1:0] SQ_HALF = SQ_W'(Q_HALF);
   localparam logic signed [KX_W-1:0] KX_HALF = KX_W'(Q_HALF);
   localparam logic signed [UA_W-1:0] UA_HALF = UA_W'(Q_HALF);
   localparam logic signed [CF_W-1:0] CF_HALF = CF_W'(Q_HALF);
   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO =
      {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]                   kind;
      logic [1:0]                   power;
      logic                         half;
      logic                         sub;
      logic [1:0]                   status;
      logic signed [VALUE_BITS-1:0] start_value;
      logic signed [VALUE_BITS-1:0] change;
   } ece_ctl_type;

   logic        vld_ff [STAGES];
   ece_ctl_type ctl_ff [STAGES];

   // stage 0: operand
   ece_ctl_type           ctl0_in;
   logic signed [X_W-1:0] x0_ff, x0_in;
   // stage 1: square and back-out scale
   logic signed [X_W-1:0]  x1_ff;
   logic signed [SQ_W-1:0] sq1_ff;
   logic signed [KX_W-1:0] kx1_ff;
   // stage 2
   logic signed [X_W-1:0]  x2_ff, sq2_ff;
   logic signed [SQ_W-1:0] p3_2_ff;
   logic signed [A_W-1:0]  a2_ff;
   // stage 3
   logic signed [X_W-1:0]  x3_ff, sq3_ff, cube3_ff;
   logic signed [SQ_W-1:0] p4_3_ff;
   logic signed [UA_W-1:0] ua3_ff;
   // stage 4
   logic signed [X_W-1:0]  xn4_ff;
   logic signed [F_W-1:0]  fb4_ff;
   // stage 5
   logic signed [F_W-1:0]  f5_ff;
   // stage 6
   logic signed [CF_W-1:0] cf6_ff;
   // output
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]               rsp_status_ff;

   logic [X_W-1:0]          dbl;
   logic signed [K_W-1:0]   back_k;
   logic signed [A_W-1:0]   back_s;
   logic signed [SQ_W-1:0]  sq_sum, p3_sum, p4_sum;
   logic signed [KX_W-1:0]  kx_sum;
   logic signed [UA_W-1:0]  ua_sum;
   logic signed [CF_W-1:0]  cf_sum;
   logic signed [X_W-1:0]   sq2_in, cube3_in, quart4;
   logic signed [X_W-1:0]   xn4_in;
   logic signed [X_W:0]     g5;
   logic signed [F_W-1:0]   f5_in;
   logic signed [CR_W-1:0]  cr7;
   logic signed [SUM_W-1:0] sum7;

   assign back_k = K_W'(overshoot) + K_W'(Q_ONE);
   assign back_s = A_W'(overshoot);

   // map progress onto the operand of the power chain
   always_comb begin
      dbl     = {head_item.progress, 1'b0};
      ctl0_in.kind        = head_item.kind;
      ctl0_in.power       = head_item.power;
      ctl0_in.status      = head_item.status;
      ctl0_in.start_value = head_item.start_value;
      ctl0_in.change      = head_item.change;
      ctl0_in.half        = 1'b0;
      ctl0_in.sub         = 1'b0;
      unique case (head_item.kind)
         KIND_IN: begin
            x0_in = X_W'(head_item.progress);
         end
         KIND_OUT: begin
            x0_in       = X_W'(Q_ONE) - X_W'(head_item.progress);
            ctl0_in.sub = 1'b1;
         end
         KIND_INOUT: begin
            ctl0_in.half = 1'b1;
            if (dbl < X_W'(Q_ONE)) begin
               x0_in = dbl;
            end else begin
               x0_in       = X_W'(2 * Q_ONE) - dbl;
               ctl0_in.sub = 1'b1;
            end
         end
         KIND_BACK: begin
            x0_in = X_W'(head_item.progress) - X_W'(Q_ONE);
         end
         default: begin
            x0_in = X_W'(head_item.progress);
         end
      endcase
   end

   always_comb begin
      sq_sum   = sq1_ff + SQ_HALF;
      sq2_in   = X_W'(sq_sum >>> Q_FRAC);
      kx_sum   = kx1_ff + KX_HALF;
      p3_sum   = p3_2_ff + SQ_HALF;
      cube3_in = X_W'(p3_sum >>> Q_FRAC);
      p4_sum   = p4_3_ff + SQ_HALF;
      quart4   = X_W'(p4_sum >>> Q_FRAC);
      ua_sum   = ua3_ff + UA_HALF;
      unique case (ctl_ff[3].power)
         POW_1:   xn4_in = x3_ff;
         POW_2:   xn4_in = sq3_ff;
         POW_3:   xn4_in = cube3_ff;
         POW_4:   xn4_in = quart4;
         default: xn4_in = x3_ff;
      endcase
   end

   // halve for in-out, reflect for out and the upper half of in-out
   always_comb begin
      if (ctl_ff[4].half) begin
         g5 = ((X_W+1)'(xn4_ff) + (X_W+1)'(1)) >>> 1;
      end else begin
         g5 = (X_W+1)'(xn4_ff);
      end
      if (ctl_ff[4].kind == KIND_BACK) begin
         f5_in = fb4_ff;
      end else if (ctl_ff[4].sub) begin
         f5_in = F_W'(Q_ONE) - F_W'(g5);
      end else begin
         f5_in = F_W'(g5);
      end
   end

   always_comb begin
      cf_sum = cf6_ff + CF_HALF;
      cr7    = CR_W'(cf_sum >>> Q_FRAC);
      sum7   = SUM_W'(cr7) + SUM_W'(ctl_ff[6].start_value);
      priority if (ctl_ff[6].status == STATUS_ZERO) begin
         rsp_value_in = OUT_W'(ctl_ff[6].start_value);
      end else if (sum7 > SAT_HI) begin
         rsp_value_in = OUT_W'(SAT_HI);
      end else if (sum7 < SAT_LO) begin
         rsp_value_in = OUT_W'(SAT_LO);
      end else begin
         rsp_value_in = OUT_W'(sum7);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff[0] <= head_valid;
         for (int i = 1; i < STAGES; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff[0] <= ctl0_in;
      for (int i = 1; i < STAGES; i++) begin
         ctl_ff[i] <= ctl_ff[i-1];
      end
      x0_ff    <= x0_in;
      x1_ff    <= x0_ff;
      sq1_ff   <= x0_ff * x0_ff;
      kx1_ff   <= back_k * x0_ff;
      x2_ff    <= x1_ff;
      sq2_ff   <= sq2_in;
      p3_2_ff  <= sq2_in * x1_ff;
      a2_ff    <= A_W'(kx_sum >>> Q_FRAC) + back_s;
      x3_ff    <= x2_ff;
      sq3_ff   <= sq2_ff;
      cube3_ff <= cube3_in;
      p4_3_ff  <= cube3_in * x2_ff;
      ua3_ff   <= sq2_ff * a2_ff;
      xn4_ff   <= xn4_in;
      fb4_ff   <= F_W'(ua_sum >>> Q_FRAC) + F_W'(Q_ONE);
      f5_ff    <= f5_in;
      cf6_ff   <= ctl_ff[5].change * f5_ff;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= ctl_ff[6].status;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* rtl/core/easing_curve_evaluator.sv */
// Top level of the easing curve evaluator: register port, front end, queue and back end.
//
// One tween value per request: raise start with the mode, elapsed time, duration, start
// value and change; the word is taken at the edge where start is high and busy is low.
// A new request can be taken every cycle while busy is low. Each result appears on
// rsp_value and rsp_status for exactly one cycle, marked by rsp_valid. A request passes
// one capture stage, a 17-stage divider that forms the progress t/d one quotient bit per
// stage, the queue, and an eight-stage back end of Q16 multipliers for the curve and the
// final scaling by the change. Results leave in request order. The receiver cannot hold
// results off, so the back end drains every cycle and busy stays low in steady operation;
// it rises only if the queue fills. The overshoot register for the back-out curve sits at
// byte address 0 and is to be written while no request is in flight.
module easing_curve_evaluator (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic [3:0]                            req_mode,
   input  logic [ece_pkg::TIME_BITS-1:0]         req_elapsed,
   input  logic [ece_pkg::TIME_BITS-1:0]         req_duration,
   input  logic signed [ece_pkg::VALUE_BITS-1:0] req_start_value,
   input  logic signed [ece_pkg::VALUE_BITS-1:0] req_change,
   // result channel
   output logic                                  rsp_valid,
   output logic signed [ece_pkg::OUT_W-1:0]      rsp_value,
   output logic [1:0]                            rsp_status,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ece_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);
   import ece_pkg::*;

   logic [OVS_W-1:0] csr_overshoot_ff, csr_overshoot_in;
   logic             csr_write;

   ece_qstat_type qstat;
   ece_item_type  push_item, head_item;
   logic          push;

   // register port: zero wait states, word index taken from paddr[2]
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      csr_overshoot_in = csr_overshoot_ff;
      if (csr_write && (paddr[2] == CSR_IDX_OVERSHOOT)) begin
         csr_overshoot_in = pwdata[OVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_overshoot_ff <= OVERSHOOT_RESET;
      end else begin
         csr_overshoot_ff <= csr_overshoot_in;
      end
   end

   // read back the overshoot, zero for unmapped words
   assign prdata = (paddr[2] == CSR_IDX_OVERSHOOT) ? 32'(csr_overshoot_ff) : '0;

   // front end: clamp, classify and divide; hold while the queue is full
   ece_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .mode        (req_mode),
      .elapsed     (req_elapsed),
      .duration    (req_duration),
      .start_value (req_start_value),
      .change      (req_change),
      .qstat       (qstat),
      .push        (push),
      .push_item   (push_item)
   );

   // queue: drained by the back end whenever it holds a word
   ece_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (!qstat.empty),
      .head_item (head_item),
      .qstat     (qstat)
   );

   // back end: curve, scale by the change, round and saturate
   ece_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!qstat.empty),
      .head_item  (head_item),
      .overshoot  (csr_overshoot_ff),
      .rsp_valid  (rsp_valid),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule
